@@ rtl/core/rsa_pkg.sv @@
// Shared types, window map and constants for the region sum readout unit.
package rsa_pkg;

  localparam int MAX_CLASSES = 10;
  localparam int SCORE_W     = 40;
  localparam int ERR_W       = 48;
  localparam int DIV_W       = 56;
  localparam int SEL_W       = 4;
  localparam logic [SCORE_W-1:0] MAX40 = '1;
  localparam logic [ERR_W-1:0]   MAX48 = '1;
  localparam logic [7:0]         DIV255 = 8'd255;

  localparam logic [1:0] CFG_GAIN       = 2'd0;
  localparam logic [1:0] CFG_ENABLE_NRM = 2'd1;
  localparam logic [1:0] CFG_ACCUM_NRM  = 2'd2;

  // class -> zone, bottom rows, right columns
  localparam logic [3:0] WIN_ZONE [MAX_CLASSES] = '{
    4'd5, 4'd5, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd11, 4'd11
  };
  localparam logic [MAX_CLASSES-1:0] WIN_BOTTOM = 10'b10_1110_1100;
  localparam logic [MAX_CLASSES-1:0] WIN_RIGHT  = 10'b00_1000_1010;

  typedef enum logic [3:0] {
    SC_IDLE, SC_RD, SC_LD, SC_DIV, SC_BASE, SC_M0, SC_M1,
    SC_SC, SC_SQ, SC_ACC, SC_MEAN, SC_MDIV, SC_OUT
  } sc_state_t;

  typedef struct packed {
    logic       rd;
    logic       clr;
  } sum_ctl_t;

  typedef struct packed {
    logic [SEL_W-1:0]   predicted_class;
    logic               correct;
    logic [SCORE_W-1:0] winning_score;
    logic [ERR_W-1:0]   squared_error;
  } result_t;

  function automatic logic in_span(input logic [5:0] v, input logic far,
                                   input int zs, input int ws);
    if (far) return (int'(v) >= zs - ws) && (int'(v) < zs);
    return int'(v) < ws;
  endfunction

  function automatic logic win_match(input logic [3:0] zone, input logic [5:0] row,
                                     input logic [5:0] col, input int k,
                                     input int zs, input int ws);
    return (zone == WIN_ZONE[k]) && in_span(row, WIN_BOTTOM[k], zs, ws) &&
           in_span(col, WIN_RIGHT[k], zs, ws);
  endfunction

endpackage

@@ rtl/core/rsa_div.sv @@
// Constant dividers: the 256/255 score scaling and the mean over the classes.
module rsa_div
  import rsa_pkg::*;
#(
  parameter int P_W         = 31,
  parameter int NUM_CLASSES = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             mean,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  // reciprocal of 255, exact for any P_W-bit dividend
  localparam int                RCP_K   = P_W + 8;
  localparam int                RCP_W   = P_W + 1;
  localparam logic [RCP_W-1:0]  RCP255  =
    RCP_W'(((64'd1 << RCP_K) + 64'(DIV255) - 64'd1) / 64'(DIV255));
  // reciprocal of the class count for one 20-bit chunk step
  localparam logic [23:0]       RCPN    =
    24'(((64'd1 << 24) + 64'(NUM_CLASSES) - 64'd1) / 64'(NUM_CLASSES));

  logic             busy_r, mean_r;
  logic [1:0]       cnt_r;
  logic [63:0]      num_r;
  logic [3:0]       rem_r;
  logic [P_W-1:0]   p_r;
  logic [2*P_W:0]   pm_r;
  logic [19:0]      chunk;
  logic [43:0]      cq_full;
  logic [15:0]      cq;
  logic [19:0]      cr;

  assign chunk    = {rem_r, num_r[63:48]};
  assign cq_full  = 44'(chunk) * 44'(RCPN);
  assign cq       = cq_full[39:24];
  assign cr       = chunk - 20'(cq) * 20'(NUM_CLASSES);
  assign done     = busy_r && (cnt_r == (mean_r ? 2'd3 : 2'd1));
  assign quotient = num_r[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 2'd1;
      if (done) busy_r <= 1'b0;
    end
  end

  // x*256/255 = x + x/255; the mean runs as four 16-bit long-division steps
  always_ff @(posedge clk) begin
    if (start) begin
      mean_r <= mean;
      p_r    <= dividend[P_W-1:0];
      num_r  <= 64'(dividend);
      rem_r  <= '0;
    end else if (busy_r) begin
      if (mean_r) begin
        num_r <= {num_r[47:0], cq};
        rem_r <= cr[3:0];
      end else if (cnt_r == 2'd0) begin
        pm_r  <= p_r * RCP255;
      end else begin
        num_r <= 64'(p_r) + 64'(pm_r[2*P_W:RCP_K]);
      end
    end
  end

endmodule

@@ rtl/core/rsa_accum.sv @@
// Window sum memory with read-modify-write pixel pipeline.
module rsa_accum
  import rsa_pkg::*;
#(
  parameter int ZONE_SIZE   = 60,
  parameter int WINDOW_SIZE = 10,
  parameter int NUM_CLASSES = 10,
  parameter int CLS_W       = 4,
  parameter int SUM_W       = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             px_acc,
  input  logic [7:0]       pixel,
  input  logic [3:0]       zone,
  input  logic [5:0]       row,
  input  logic [5:0]       col,
  input  sum_ctl_t         ctl,
  input  logic [CLS_W-1:0] sc_addr,
  output logic [SUM_W-1:0] sum_q
);

  logic [SUM_W-1:0] mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] vld_r;
  logic [SUM_W-1:0] mem_q;
  logic             hit;
  logic [CLS_W-1:0] hit_cls, rd_addr;
  logic             s1_vld_r;
  logic [CLS_W-1:0] s1_cls_r;
  logic [7:0]       s1_pix_r;
  logic             fwd_r, rv_r;
  logic [SUM_W-1:0] fwd_d_r, wr_d;

  always_comb begin
    hit     = 1'b0;
    hit_cls = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (win_match(zone, row, col, k, ZONE_SIZE, WINDOW_SIZE)) begin
        hit     = 1'b1;
        hit_cls = CLS_W'(k);
      end
    end
  end

  assign rd_addr = ctl.rd ? sc_addr : hit_cls;
  assign sum_q   = fwd_r ? fwd_d_r : (rv_r ? mem_q : '0);
  assign wr_d    = sum_q + SUM_W'(s1_pix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      vld_r    <= '0;
      fwd_r    <= 1'b0;
      rv_r     <= 1'b0;
    end else begin
      s1_vld_r <= px_acc && hit;
      fwd_r    <= s1_vld_r && (s1_cls_r == rd_addr);
      rv_r     <= vld_r[rd_addr] || (s1_vld_r && (s1_cls_r == rd_addr));
      if (ctl.clr) vld_r <= '0;
      else if (s1_vld_r) vld_r[s1_cls_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s1_cls_r <= hit_cls;
    s1_pix_r <= pixel;
    fwd_d_r  <= wr_d;
    mem_q    <= mem[rd_addr];
    if (s1_vld_r) mem[s1_cls_r] <= wr_d;
  end

endmodule

@@ rtl/core/rsa_score.sv @@
// End-of-frame scoring sequencer with norm memory, argmax and error.
module rsa_score
  import rsa_pkg::*;
#(
  parameter int WINDOW_SIZE = 10,
  parameter int NUM_CLASSES = 10,
  parameter int CLS_W       = 4,
  parameter int SUM_W       = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [3:0]       label,
  input  logic [15:0]      gain,
  input  logic             norm_en,
  input  logic             accumulate_norm,
  input  logic             out_free,
  input  logic [SUM_W-1:0] sum_q,
  output sum_ctl_t         ctl,
  output logic [CLS_W-1:0] sc_addr,
  output logic             res_ld,
  output result_t          res
);

  localparam logic [SCORE_W-1:0] TARGET = SCORE_W'(WINDOW_SIZE * WINDOW_SIZE) << 16;
  localparam int P_W = 16 + SUM_W;

  sc_state_t state_r, state_nxt;
  logic [CLS_W-1:0]   idx_r;
  logic [SCORE_W-1:0] norm_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] nv_r;
  logic [SCORE_W-1:0] norm_q, norm_r, score_r, best_r, d_r;
  logic               nvq_r;
  logic [CLS_W-1:0]   best_i_r;
  logic [59:0]        prod_r;
  logic [35:0]        hh_r;
  logic [33:0]        hl_r;
  logic [31:0]        ll_r;
  logic               cap_r;
  logic [DIV_W-1:0]   err_r;
  logic               div_start, div_done, div_mean;
  logic [DIV_W-1:0]   div_a, div_q;
  logic [79:0]        macc;
  logic [SCORE_W:0]   nsum;
  logic [SCORE_W-1:0] tgt;
  logic               last;

  rsa_div #(
    .P_W(P_W), .NUM_CLASSES(NUM_CLASSES)
  ) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .mean(div_mean), .dividend(div_a),
    .done(div_done), .quotient(div_q)
  );

  assign sc_addr = idx_r;
  assign last    = idx_r == CLS_W'(NUM_CLASSES - 1);
  assign tgt     = (SEL_W'(idx_r) == label) ? TARGET : '0;
  assign macc    = 80'(prod_r) + ((80'(score_r) * 80'(norm_r[39:20])) << 20);
  assign nsum    = {1'b0, norm_r} + {1'b0, score_r};

  always_comb begin
    state_nxt = state_r;
    ctl       = '{rd: 1'b0, clr: 1'b0};
    div_start = 1'b0;
    div_mean  = 1'b0;
    div_a     = DIV_W'(gain) * DIV_W'(sum_q);
    res_ld    = 1'b0;
    unique case (state_r)
      SC_IDLE: if (start) state_nxt = SC_RD;
      SC_RD: begin
        ctl.rd    = 1'b1;
        state_nxt = SC_LD;
      end
      SC_LD: begin
        div_start = 1'b1;
        state_nxt = SC_DIV;
      end
      SC_DIV:  if (div_done) state_nxt = SC_BASE;
      SC_BASE: state_nxt = norm_en ? SC_M0 : SC_SC;
      SC_M0:   state_nxt = SC_M1;
      SC_M1:   state_nxt = SC_SC;
      SC_SC:   state_nxt = SC_SQ;
      SC_SQ:   state_nxt = SC_ACC;
      SC_ACC:  state_nxt = last ? SC_MEAN : SC_RD;
      SC_MEAN: begin
        div_start = 1'b1;
        div_mean  = 1'b1;
        div_a     = err_r;
        state_nxt = SC_MDIV;
      end
      SC_MDIV: if (div_done) state_nxt = SC_OUT;
      SC_OUT: begin
        if (out_free) begin
          res_ld    = 1'b1;
          ctl.clr   = 1'b1;
          state_nxt = SC_IDLE;
        end
      end
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      idx_r   <= '0;
      nv_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == SC_IDLE) idx_r <= '0;
      else if (state_r == SC_ACC && !last) idx_r <= idx_r + 1'b1;
      if (state_r == SC_SC && accumulate_norm) nv_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    norm_q <= norm_mem[idx_r];
    nvq_r  <= nv_r[idx_r];
    if (state_r == SC_SC && accumulate_norm)
      norm_mem[idx_r] <= nsum[SCORE_W] ? MAX40 : nsum[SCORE_W-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      SC_IDLE: err_r <= '0;
      SC_LD:   norm_r <= nvq_r ? norm_q : '0;
      SC_BASE: score_r <= (div_q > DIV_W'(MAX40)) ? MAX40 : div_q[SCORE_W-1:0];
      SC_M0:   prod_r <= score_r * norm_r[19:0];
      SC_M1:   score_r <= (macc[79:56] != '0) ? MAX40 : macc[55:16];
      SC_SC: begin
        if (idx_r == '0 || score_r > best_r) begin
          best_r   <= score_r;
          best_i_r <= idx_r;
        end
        d_r <= (score_r > tgt) ? score_r - tgt : tgt - score_r;
      end
      SC_SQ: begin
        cap_r <= d_r[39:34] != '0;
        hh_r  <= d_r[33:16] * d_r[33:16];
        hl_r  <= d_r[33:16] * d_r[15:0];
        ll_r  <= d_r[15:0] * d_r[15:0];
      end
      SC_ACC:
        err_r <= err_r + (cap_r ? DIV_W'(1) << 52 :
                 (DIV_W'(hh_r) << 16) + (DIV_W'(hl_r) << 1) + DIV_W'(ll_r[31:16]));
      default: ;
    endcase
  end

  always_comb begin
    res.predicted_class = SEL_W'(best_i_r);
    res.correct         = SEL_W'(best_i_r) == label;
    res.winning_score   = best_r;
    res.squared_error   = (div_q > DIV_W'(MAX48)) ? MAX48 : div_q[ERR_W-1:0];
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= CLS_W'(NUM_CLASSES - 1)) else $error("class index out of range");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == SC_LD || state_r == SC_MEAN)) else $error("stray divide");
  a_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_ld |-> out_free) else $error("result load into busy output");
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> state_r == SC_IDLE) else $error("clear outside frame end");

endmodule

@@ rtl/core/region_sum_argmax_readout_unit.sv @@
// Top level of the region sum argmax readout unit.
//  channel | signals                                          | handshake
//  in      | pixel zone row col label end_of_frame            | valid/ready
//  out     | predicted_class correct winning_score squared_err | valid/ready
//  cfg     | wr_en index wdata                                | write only
// One pixel beat per cycle while a frame streams; the sum memory is read,
// added and written back in a two-stage loop with forwarding.
// End of frame stalls input while all classes are scored and, if enabled,
// normalised, plus any wait for the output register to free up.
// Reset clears sums, norms and registers at once through valid bits.
// A waiting result does not stall input; a second frame end does.
module region_sum_argmax_readout_unit
  import rsa_pkg::*;
#(
  parameter int ZONE_SIZE   = 60,
  parameter int WINDOW_SIZE = 10,
  parameter int NUM_CLASSES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel,
  input  logic [3:0]  in_zone,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic [3:0]  in_label,
  input  logic        in_end_of_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_predicted_class,
  output logic        out_correct,
  output logic [39:0] out_winning_score,
  output logic [47:0] out_squared_error,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SUM_W = $clog2(WINDOW_SIZE * WINDOW_SIZE * 255 + 1);

  logic [15:0] gain_r;
  logic        en_norm_r, acc_norm_r;
  logic        busy_r, start_r, out_valid_r;
  logic [3:0]  label_r;
  logic        px_acc, res_ld;
  result_t     res, out_r;
  sum_ctl_t    ctl;
  logic [CLS_W-1:0] sc_addr;
  logic [SUM_W-1:0] sum_q;

  assign in_ready = !busy_r;
  assign px_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= 16'd256;
      en_norm_r  <= 1'b0;
      acc_norm_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GAIN:       gain_r     <= cfg_wdata;
        CFG_ENABLE_NRM: en_norm_r  <= cfg_wdata[0];
        CFG_ACCUM_NRM:  acc_norm_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= px_acc && in_end_of_frame;
      if (px_acc && in_end_of_frame) busy_r <= 1'b1;
      else if (res_ld) busy_r <= 1'b0;
      if (res_ld) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (px_acc && in_end_of_frame) label_r <= in_label;
    if (res_ld) out_r <= res;
  end

  rsa_accum #(
    .ZONE_SIZE(ZONE_SIZE), .WINDOW_SIZE(WINDOW_SIZE), .NUM_CLASSES(NUM_CLASSES),
    .CLS_W(CLS_W), .SUM_W(SUM_W)
  ) u_accum (
    .clk(clk), .rst_n(rst_n), .px_acc(px_acc), .pixel(in_pixel), .zone(in_zone),
    .row(in_row), .col(in_col), .ctl(ctl), .sc_addr(sc_addr), .sum_q(sum_q)
  );

  rsa_score #(
    .WINDOW_SIZE(WINDOW_SIZE), .NUM_CLASSES(NUM_CLASSES), .CLS_W(CLS_W), .SUM_W(SUM_W)
  ) u_score (
    .clk(clk), .rst_n(rst_n), .start(start_r), .label(label_r), .gain(gain_r),
    .norm_en(en_norm_r), .accumulate_norm(acc_norm_r),
    .out_free(!out_valid_r || out_ready), .sum_q(sum_q), .ctl(ctl),
    .sc_addr(sc_addr), .res_ld(res_ld), .res(res)
  );

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_r.predicted_class;
  assign out_correct         = out_r.correct;
  assign out_winning_score   = out_r.winning_score;
  assign out_squared_error   = out_r.squared_error;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !px_acc) else $error("pixel taken during scoring");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> busy_r) else $error("scoring started while idle");
  a_ld_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_ld |-> busy_r) else $error("result without frame");

endmodule
